[rtl/core/pptw_pkg.sv]
// shared types and constants for the pressure point window tracker
`timescale 1ns / 1ps

package pptw_pkg;

    localparam int MAX_POINTS_DEF = 16;
    localparam int MAX_RESULTS    = 32;

    localparam int CMD_W    = 2;
    localparam int SLOT_W   = 4;
    localparam int VALUE_W  = 24;
    localparam int PCOUNT_W = 5;
    localparam int INDEX_W  = 4;
    localparam int SCALE_W  = 12;
    localparam int FRAC_W   = 8;
    localparam int PROD_W   = VALUE_W + SCALE_W;
    localparam int CMP_W    = PROD_W + 2;
    localparam int EVT_W    = $clog2(MAX_RESULTS + 1);
    localparam int CFG_IDX_W = 1;

    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BEGIN  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_END    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTER_SCALE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXIT_SCALE  = 1'b1;

    localparam logic EVT_ENTERED = 1'b0;
    localparam logic EVT_EXITED  = 1'b1;

    typedef struct packed {
        logic load;
        logic stop;
        logic scan_start;
        logic scan_rd;
        logic scan_step;
        logic scan_done;
        logic smp_start;
        logic pt_rd;
        logic emit_enter;
        logic emit_exit;
        logic flush;
    } dp_cmd_t;

    typedef struct packed {
        logic tracking;
        logic count_ok;
        logic scan_last;
        logic enter_hit;
        logic exit_hit;
        logic in_window;
        logic pos_last;
        logic pend_valid;
        logic out_free;
        logic cap_hit;
    } dp_sts_t;

endpackage

[rtl/core/pptw_ctrl.sv]
// controller state machine for the pressure point window tracker
`timescale 1ns / 1ps

module pptw_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [pptw_pkg::CMD_W-1:0]    in_command,
    output logic                          in_ready,
    input  pptw_pkg::dp_sts_t             sts,
    output pptw_pkg::dp_cmd_t             cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN_RD  = 3'd1;
    localparam logic [2:0] S_SCAN_CMP = 3'd2;
    localparam logic [2:0] S_SCAN_END = 3'd3;
    localparam logic [2:0] S_RD       = 3'd4;
    localparam logic [2:0] S_EVAL     = 3'd5;
    localparam logic [2:0] S_FLUSH    = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (in_command)
                        pptw_pkg::CMD_LOAD:
                        begin
                            cmd.load = 1'b1;
                        end
                        pptw_pkg::CMD_BEGIN:
                        begin
                            cmd.stop = 1'b1;
                            if (sts.count_ok)
                            begin
                                cmd.scan_start = 1'b1;
                                state_next     = S_SCAN_RD;
                            end
                        end
                        pptw_pkg::CMD_END:
                        begin
                            cmd.stop = 1'b1;
                        end
                        pptw_pkg::CMD_SAMPLE:
                        begin
                            if (sts.tracking)
                            begin
                                cmd.smp_start = 1'b1;
                                state_next    = S_RD;
                            end
                        end
                        default:
                        begin
                            cmd = '0;
                        end
                    endcase
                end
            end
            S_SCAN_RD:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                cmd.scan_step = 1'b1;
                state_next    = sts.scan_last ? S_SCAN_END : S_SCAN_RD;
            end
            S_SCAN_END:
            begin
                cmd.scan_done = 1'b1;
                state_next    = S_IDLE;
            end
            S_RD:
            begin
                cmd.pt_rd  = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (!sts.in_window)
                begin
                    if (!sts.enter_hit || sts.cap_hit)
                    begin
                        state_next = S_FLUSH;
                    end
                    else if (sts.out_free)
                    begin
                        cmd.emit_enter = 1'b1;
                    end
                end
                else
                begin
                    if (!sts.exit_hit || sts.cap_hit)
                    begin
                        state_next = S_FLUSH;
                    end
                    else if (sts.out_free)
                    begin
                        cmd.emit_exit = 1'b1;
                        state_next    = sts.pos_last ? S_FLUSH : S_RD;
                    end
                end
            end
            S_FLUSH:
            begin
                if (!sts.pend_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/pptw_dp.sv]
// datapath: point table, base step scan, window compare and event output
`timescale 1ns / 1ps

module pptw_dp #(
    parameter int MAX_POINTS = pptw_pkg::MAX_POINTS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [pptw_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pptw_pkg::SCALE_W-1:0]          cfg_data,
    input  logic [pptw_pkg::SLOT_W-1:0]           in_slot,
    input  logic [pptw_pkg::VALUE_W-1:0]          in_value,
    input  logic                                  in_reverse,
    input  logic [pptw_pkg::PCOUNT_W-1:0]         in_point_count,
    input  pptw_pkg::dp_cmd_t                     cmd,
    output pptw_pkg::dp_sts_t                     sts,
    input  logic                                  out_ready,
    output logic                                  out_valid,
    output logic                                  out_kind,
    output logic [pptw_pkg::INDEX_W-1:0]          out_index,
    output logic [pptw_pkg::VALUE_W-1:0]          out_value,
    output logic                                  out_still,
    output logic                                  out_last
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int CW    = (CNT_W > pptw_pkg::PCOUNT_W) ? CNT_W : pptw_pkg::PCOUNT_W;
    localparam int RW    = ((CNT_W > pptw_pkg::SLOT_W) ? CNT_W : pptw_pkg::SLOT_W) + 1;
    localparam int VW    = pptw_pkg::VALUE_W;
    localparam int PW    = pptw_pkg::PROD_W;
    localparam int XW    = pptw_pkg::CMP_W;
    localparam int SW    = pptw_pkg::SCALE_W;
    localparam int EW    = pptw_pkg::EVT_W;

    function automatic logic [IDX_W-1:0] slot_wrap(input logic [pptw_pkg::SLOT_W-1:0] s);
        logic [RW-1:0] r;
        r = RW'(s);
        for (int k = 0; k < 8; k++)
        begin
            if (r >= RW'(MAX_POINTS))
            begin
                r = r - RW'(MAX_POINTS);
            end
        end
        return IDX_W'(r);
    endfunction

    logic [VW-1:0]    tbl_mem [MAX_POINTS];
    logic [VW-1:0]    rd_data_reg;

    logic [SW-1:0]    enter_scale_reg;
    logic [SW-1:0]    exit_scale_reg;

    logic [CNT_W-1:0] active_count_reg;
    logic [VW-1:0]    base_step_reg;
    logic [CNT_W-1:0] position_reg;
    logic             inside_reg;
    logic             tracking_reg;
    logic             reverse_reg;

    logic [CNT_W-1:0] scan_n_reg;
    logic [CNT_W-1:0] scan_idx_reg;
    logic             scan_rev_reg;
    logic [VW-1:0]    prev_reg;
    logic [VW-1:0]    best_reg;
    logic             found_reg;

    logic [VW-1:0]    sample_reg;
    logic [PW-1:0]    d_enter_reg;
    logic [PW-1:0]    d_exit_reg;
    logic [EW-1:0]    evt_cnt_reg;

    logic             pend_valid_reg;
    logic             pend_kind_reg;
    logic [pptw_pkg::INDEX_W-1:0] pend_index_reg;
    logic [VW-1:0]    pend_value_reg;
    logic             pend_still_reg;

    logic             out_valid_reg;
    logic             out_kind_reg;
    logic [pptw_pkg::INDEX_W-1:0] out_index_reg;
    logic [VW-1:0]    out_value_reg;
    logic             out_still_reg;
    logic             out_last_reg;

    logic [CW-1:0]    pc_wide;
    logic [CNT_W-1:0] n_sat;
    logic [CNT_W-1:0] pt_full;
    logic [IDX_W-1:0] pt_idx;
    logic [IDX_W-1:0] rd_addr;
    logic signed [VW:0]   gap_diff;
    logic [VW-1:0]    gap_abs;
    logic signed [VW:0]   sd;
    logic signed [XW-1:0] sd_sh;
    logic signed [XW-1:0] enter_sum;
    logic signed [XW-1:0] exit_sum;
    logic             pos_last;
    logic             ev_valid;
    logic             ev_kind;
    logic             ev_still;
    logic             push_out;
    logic             push_last;

    assign pc_wide = CW'(in_point_count);
    assign n_sat   = (pc_wide > CW'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : CNT_W'(pc_wide);

    assign pt_full = reverse_reg ? (active_count_reg - CNT_W'(1) - position_reg) : position_reg;
    assign pt_idx  = pt_full[IDX_W-1:0];
    assign rd_addr = cmd.scan_rd ? scan_idx_reg[IDX_W-1:0] : pt_idx;

    assign gap_diff = $signed({rd_data_reg[VW-1], rd_data_reg}) - $signed({prev_reg[VW-1], prev_reg});
    assign gap_abs  = gap_diff[VW] ? VW'(-gap_diff) : gap_diff[VW-1:0];

    assign sd = reverse_reg
              ? ($signed({rd_data_reg[VW-1], rd_data_reg}) - $signed({sample_reg[VW-1], sample_reg}))
              : ($signed({sample_reg[VW-1], sample_reg}) - $signed({rd_data_reg[VW-1], rd_data_reg}));
    assign sd_sh     = {{(XW - VW - 1 - pptw_pkg::FRAC_W){sd[VW]}}, sd, {pptw_pkg::FRAC_W{1'b0}}};
    assign enter_sum = sd_sh + $signed(XW'(d_enter_reg));
    assign exit_sum  = sd_sh - $signed(XW'(d_exit_reg));

    assign pos_last  = (CNT_W'(position_reg + CNT_W'(1)) == active_count_reg);
    assign ev_valid  = cmd.emit_enter || cmd.emit_exit;
    assign ev_kind   = cmd.emit_exit ? pptw_pkg::EVT_EXITED : pptw_pkg::EVT_ENTERED;
    assign ev_still  = cmd.emit_exit ? !pos_last : 1'b1;
    assign push_out  = pend_valid_reg && (ev_valid || cmd.flush);
    assign push_last = cmd.flush;

    always_comb
    begin
        sts            = '0;
        sts.tracking   = tracking_reg;
        sts.count_ok   = (n_sat >= CNT_W'(2));
        sts.scan_last  = (CNT_W'(scan_idx_reg + CNT_W'(1)) == scan_n_reg);
        sts.enter_hit  = !enter_sum[XW-1];
        sts.exit_hit   = !exit_sum[XW-1];
        sts.in_window  = inside_reg;
        sts.pos_last   = pos_last;
        sts.pend_valid = pend_valid_reg;
        sts.out_free   = !out_valid_reg || out_ready;
        sts.cap_hit    = (evt_cnt_reg >= EW'(pptw_pkg::MAX_RESULTS));
    end

    // point table
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            tbl_mem[slot_wrap(in_slot)] <= in_value;
        end
        if (cmd.scan_rd || cmd.pt_rd)
        begin
            rd_data_reg <= tbl_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enter_scale_reg <= '0;
            exit_scale_reg  <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == pptw_pkg::CFG_ENTER_SCALE)
            begin
                enter_scale_reg <= cfg_data;
            end
            else
            begin
                exit_scale_reg <= cfg_data;
            end
        end
    end

    // tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_count_reg <= '0;
            base_step_reg    <= '0;
            position_reg     <= '0;
            inside_reg       <= 1'b0;
            tracking_reg     <= 1'b0;
            reverse_reg      <= 1'b0;
        end
        else if (cmd.stop)
        begin
            active_count_reg <= '0;
            base_step_reg    <= '0;
            position_reg     <= '0;
            inside_reg       <= 1'b0;
            tracking_reg     <= 1'b0;
        end
        else if (cmd.scan_done)
        begin
            if (found_reg)
            begin
                base_step_reg    <= best_reg;
                active_count_reg <= scan_n_reg;
                reverse_reg      <= scan_rev_reg;
                position_reg     <= '0;
                inside_reg       <= 1'b0;
                tracking_reg     <= 1'b1;
            end
        end
        else if (cmd.emit_enter)
        begin
            inside_reg <= 1'b1;
        end
        else if (cmd.emit_exit)
        begin
            inside_reg   <= 1'b0;
            position_reg <= CNT_W'(position_reg + CNT_W'(1));
            if (pos_last)
            begin
                tracking_reg <= 1'b0;
            end
        end
    end

    // base step scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_n_reg   <= '0;
            scan_idx_reg <= '0;
            scan_rev_reg <= 1'b0;
            found_reg    <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            scan_n_reg   <= n_sat;
            scan_idx_reg <= '0;
            scan_rev_reg <= in_reverse;
            found_reg    <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            scan_idx_reg <= CNT_W'(scan_idx_reg + CNT_W'(1));
            if (scan_idx_reg != '0 && gap_abs != '0 && (!found_reg || gap_abs < best_reg))
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_step)
        begin
            prev_reg <= rd_data_reg;
            if (scan_idx_reg != '0 && gap_abs != '0 && (!found_reg || gap_abs < best_reg))
            begin
                best_reg <= gap_abs;
            end
        end
        if (cmd.smp_start)
        begin
            sample_reg  <= in_value;
            d_enter_reg <= PW'(base_step_reg) * PW'(enter_scale_reg);
            d_exit_reg  <= PW'(base_step_reg) * PW'(exit_scale_reg);
        end
    end

    // event hold and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.smp_start)
            begin
                evt_cnt_reg <= '0;
            end
            else if (ev_valid)
            begin
                evt_cnt_reg <= EW'(evt_cnt_reg + EW'(1));
            end

            if (ev_valid)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (push_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev_valid)
        begin
            pend_kind_reg  <= ev_kind;
            pend_index_reg <= pptw_pkg::INDEX_W'(pt_idx);
            pend_value_reg <= rd_data_reg;
            pend_still_reg <= ev_still;
        end
        if (push_out)
        begin
            out_kind_reg  <= pend_kind_reg;
            out_index_reg <= pend_index_reg;
            out_value_reg <= pend_value_reg;
            out_still_reg <= pend_still_reg;
            out_last_reg  <= push_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_index = out_index_reg;
    assign out_value = out_value_reg;
    assign out_still = out_still_reg;
    assign out_last  = out_last_reg;

    a_track_range: assert property (@(posedge clk) disable iff (!rst_n)
        tracking_reg |-> (active_count_reg >= CNT_W'(2)) && (position_reg < active_count_reg))
        else $error("tracking with position outside the active points");

    a_track_step: assert property (@(posedge clk) disable iff (!rst_n)
        tracking_reg |-> (base_step_reg != '0))
        else $error("tracking with zero base step");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push_out |-> (!out_valid_reg || out_ready))
        else $error("event pushed over an untaken beat");

    a_evt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        evt_cnt_reg <= EW'(pptw_pkg::MAX_RESULTS))
        else $error("event count beyond result limit");

    a_flush_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |=> !pend_valid_reg)
        else $error("held event survives a flush");

endmodule

[rtl/core/pressure_point_window_tracker.sv]
// top level of the pressure point window tracker
`timescale 1ns / 1ps

// channel   direction  tdata                                            tuser        tlast
// s_axis    in         slot, value, reverse, point_count (40 bits)      command      -
// m_axis    out        point_index, point_value, still_tracking (32)    event_kind   last
// cfg       in         cfg_index 0 enter_scale, 1 exit_scale            -            -
//
// load and end are done straight from idle; begin (count saturated, only a stop below
// two points) walks the point table through its single read port, reading and comparing
// each gap in turn, and tracking starts only on a nonzero smallest gap
// a sample evaluates the points in turn, emitting enter and exit events, then flushes the held one
// reset clears all tracking state; the point table holds no reset value
// a stalled output holds the sample in progress, and no new beat is taken meanwhile

module pressure_point_window_tracker #(
    parameter int MAX_POINTS = pptw_pkg::MAX_POINTS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [39:0]                        s_axis_tdata,  // slot, value, reverse, point_count
    input  logic [pptw_pkg::CMD_W-1:0]         s_axis_tuser,  // command
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [31:0]                        m_axis_tdata,  // point_index, point_value, still_tracking
    output logic                               m_axis_tuser,  // event_kind
    output logic                               m_axis_tlast,
    input  logic                               cfg_we,
    input  logic [pptw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pptw_pkg::SCALE_W-1:0]       cfg_data
);

    pptw_pkg::dp_cmd_t cmd;
    pptw_pkg::dp_sts_t sts;

    logic [pptw_pkg::INDEX_W-1:0] out_index;
    logic [pptw_pkg::VALUE_W-1:0] out_value;
    logic                         out_still;

    pptw_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_command (s_axis_tuser),
        .in_ready   (s_axis_tready),
        .sts        (sts),
        .cmd        (cmd)
    );

    pptw_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_slot        (s_axis_tdata[3:0]),
        .in_value       (s_axis_tdata[27:4]),
        .in_reverse     (s_axis_tdata[28]),
        .in_point_count (s_axis_tdata[33:29]),
        .cmd            (cmd),
        .sts            (sts),
        .out_ready      (m_axis_tready),
        .out_valid      (m_axis_tvalid),
        .out_kind       (m_axis_tuser),
        .out_index      (out_index),
        .out_value      (out_value),
        .out_still      (out_still),
        .out_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, out_still, out_value, out_index};

endmodule

[tb/testbench.sv]
// self-checking testbench for the pressure point window tracker
`timescale 1ns / 1ps

module testbench;

    localparam int CMD_W          = pptw_pkg::CMD_W;
    localparam int SLOT_W         = pptw_pkg::SLOT_W;
    localparam int VALUE_W        = pptw_pkg::VALUE_W;
    localparam int PCOUNT_W       = pptw_pkg::PCOUNT_W;
    localparam int INDEX_W        = pptw_pkg::INDEX_W;
    localparam int SCALE_W        = pptw_pkg::SCALE_W;
    localparam int CFG_IDX_W      = pptw_pkg::CFG_IDX_W;
    localparam int MAX_POINTS_DEF = pptw_pkg::MAX_POINTS_DEF;

    typedef struct packed {
        logic                      kind;
        logic [INDEX_W-1:0]        point_index;
        logic [VALUE_W-1:0]        point_value;
        logic                      still_tracking;
        logic                      last;
    } window_event_t;

    class window_event_board;
        logic signed [VALUE_W-1:0] set_points [MAX_POINTS_DEF];
        int unsigned               active_count;
        int unsigned               position;
        longint                    base_step;
        bit                        inside_window;
        bit                        tracking;
        bit                        going_reverse;
        int unsigned               enter_scale;
        int unsigned               exit_scale;
        window_event_t             expected_events[$];
        int                        mismatches;

        function new();
            foreach (set_points[i])
                set_points[i] = '0;
            clear_tracking();
            going_reverse = 1'b0;
            enter_scale   = 0;
            exit_scale    = 0;
            mismatches    = 0;
        endfunction

        function void clear_tracking();
            tracking      = 1'b0;
            inside_window = 1'b0;
            position      = 0;
            base_step     = 0;
            active_count  = 0;
        endfunction

        function void note_beat(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot,
                                logic signed [VALUE_W-1:0] value, logic rev,
                                logic [PCOUNT_W-1:0] count);
            window_event_t batch[$];
            window_event_t ev;
            longint        p;
            longint        t;
            longint        gap;
            longint        best;
            longint        d_enter;
            longint        d_exit;
            int unsigned   n;
            int unsigned   idx;
            bit            found;
            bit            hit;
            case (cmd)
                pptw_pkg::CMD_LOAD:
                    set_points[slot] = value;
                pptw_pkg::CMD_BEGIN:
                begin
                    clear_tracking();
                    n     = (count > MAX_POINTS_DEF) ? MAX_POINTS_DEF : count;
                    found = 1'b0;
                    best  = 0;
                    for (int i = 1; i < n; i++)
                    begin
                        gap = longint'(set_points[i]) - longint'(set_points[i-1]);
                        if (gap < 0)
                            gap = -gap;
                        if (gap != 0 && (!found || gap < best))
                        begin
                            best  = gap;
                            found = 1'b1;
                        end
                    end
                    if (n >= 2 && found)
                    begin
                        base_step     = best;
                        active_count  = n;
                        going_reverse = rev;
                        tracking      = 1'b1;
                    end
                end
                pptw_pkg::CMD_END:
                    clear_tracking();
                pptw_pkg::CMD_SAMPLE:
                begin
                    p       = longint'(value) * 256;
                    d_enter = base_step * longint'(enter_scale);
                    d_exit  = base_step * longint'(exit_scale);
                    while (tracking && position < active_count)
                    begin
                        idx = going_reverse ? active_count - 1 - position : position;
                        t   = longint'(set_points[idx]) * 256;
                        if (!inside_window)
                        begin
                            hit = going_reverse ? (p <= t + d_enter) : (p >= t - d_enter);
                            if (!hit)
                                break;
                            inside_window = 1'b1;
                            ev = {pptw_pkg::EVT_ENTERED, idx[INDEX_W-1:0], set_points[idx],
                                  tracking, 1'b0};
                            batch.insert(batch.size(), ev);
                        end
                        hit = going_reverse ? (p <= t - d_exit) : (p >= t + d_exit);
                        if (!hit)
                            break;
                        inside_window = 1'b0;
                        position++;
                        if (position >= active_count)
                            tracking = 1'b0;
                        ev = {pptw_pkg::EVT_EXITED, idx[INDEX_W-1:0], set_points[idx],
                              tracking, 1'b0};
                        batch.insert(batch.size(), ev);
                    end
                    foreach (batch[i])
                    begin
                        ev      = batch[i];
                        ev.last = (i == batch.size() - 1);
                        expected_events.insert(expected_events.size(), ev);
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        function void report_event(string what, window_event_t want, window_event_t got);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t %s: expected kind %0d index %0d value %h still %0d last %0d, got kind %0d index %0d value %h still %0d last %0d",
                         $realtime, what, want.kind, want.point_index, want.point_value,
                         want.still_tracking, want.last, got.kind, got.point_index,
                         got.point_value, got.still_tracking, got.last);
        endfunction

        function void check_event(window_event_t got);
            window_event_t want;
            if (expected_events.size() == 0)
                report_event("unexpected event", '0, got);
            else
            begin
                want = expected_events.pop_front();
                if (want !== got)
                    report_event("event mismatch", want, got);
            end
        endfunction
    endclass

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [39:0]            s_axis_tdata  = '0;  // slot, value, reverse, point_count
    logic [CMD_W-1:0]       s_axis_tuser  = pptw_pkg::CMD_LOAD;  // command
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [31:0]            m_axis_tdata;  // point_index, point_value, still_tracking
    logic                   m_axis_tuser;  // event_kind
    logic                   m_axis_tlast;
    logic                   cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index     = pptw_pkg::CFG_ENTER_SCALE;
    logic [SCALE_W-1:0]     cfg_data      = '0;

    window_event_board board = new();
    int                send_idle_pct = 22;
    int                recv_idle_pct = 81;
    int                beats_sent    = 0;

    pressure_point_window_tracker u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin : event_monitor
        window_event_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[27:4], m_axis_tdata[28],
                   m_axis_tlast};
            board.check_event(got);
        end
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                             input logic signed [VALUE_W-1:0] value, input logic rev,
                             input logic [PCOUNT_W-1:0] count);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, count, rev, value, slot};
        s_axis_tuser  <= cmd;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_beat(cmd, slot, value, rev, count);
        beats_sent++;
    endtask

    task automatic write_scales(input int unsigned enter_val, input int unsigned exit_val);
        cfg_we    <= 1'b1;
        cfg_index <= pptw_pkg::CFG_ENTER_SCALE;
        cfg_data  <= enter_val[SCALE_W-1:0];
        @(posedge clk);
        cfg_index <= pptw_pkg::CFG_EXIT_SCALE;
        cfg_data  <= exit_val[SCALE_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.enter_scale = enter_val;
        board.exit_scale  = exit_val;
    endtask

    // waits out the event stream, then the longest begin scan
    task automatic drain_events();
        s_axis_tvalid <= 1'b0;
        while (board.expected_events.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic logic signed [VALUE_W-1:0] clamp_pressure(longint v);
        if (v > 8388607)
            return 24'sh7FFFFF;
        if (v < -8388608)
            return 24'sh800000;
        return v[VALUE_W-1:0];
    endfunction

    task automatic send_noise();
        int burst;
        burst = $urandom_range(4, 1);
        repeat (burst)
            send_beat(CMD_W'($urandom_range(3)), SLOT_W'($urandom_range(15)),
                      VALUE_W'($urandom), 1'($urandom_range(1)),
                      PCOUNT_W'($urandom_range(31)));
    endtask

    // ascending table, begin, then a pressure ramp across every window
    task automatic run_sweep();
        longint      pts [MAX_POINTS_DEF];
        longint      margin;
        longint      span;
        longint      lo;
        longint      hi;
        longint      v;
        longint      step;
        int unsigned n;
        int unsigned gap_max;
        int unsigned samples;
        int unsigned count;
        bit          rev;
        n       = ($urandom_range(9) == 0) ? $urandom_range(16, 7) : $urandom_range(6, 2);
        gap_max = $urandom_range(1) ? $urandom_range(16, 1) : $urandom_range(200000, 1);
        span    = longint'(n) * gap_max;
        margin  = 17 * longint'(gap_max) + 4;
        pts[0]  = -8388608 + margin
                  + longint'($urandom_range(int'(16777215 - span - 2 * margin)));
        for (int i = 1; i < n; i++)
            pts[i] = pts[i-1] + (($urandom_range(7) == 0) ? 0 : $urandom_range(gap_max, 1));
        for (int i = 0; i < n; i++)
            send_beat(pptw_pkg::CMD_LOAD, SLOT_W'(i), VALUE_W'(pts[i]),
                      1'($urandom_range(1)), PCOUNT_W'($urandom_range(31)));
        rev   = 1'($urandom_range(1));
        count = ($urandom_range(9) == 0) ? $urandom_range(31) : n;
        send_beat(pptw_pkg::CMD_BEGIN, SLOT_W'($urandom_range(15)), VALUE_W'($urandom), rev,
                  PCOUNT_W'(count));
        samples = $urandom_range(3 * n + 4, n + 2);
        lo      = pts[0] - margin;
        hi      = pts[n-1] + margin;
        step    = (hi - lo) / samples + 1;
        v       = rev ? hi : lo;
        repeat (samples)
        begin
            case ($urandom_range(19))
                0:
                    send_beat(pptw_pkg::CMD_END, SLOT_W'($urandom_range(15)),
                              VALUE_W'($urandom), 1'($urandom_range(1)),
                              PCOUNT_W'($urandom_range(31)));
                1:
                    v = rev ? lo : hi;
                2:
                    v = rev ? v + step : v - step;
                default:
                    v = rev ? v - $urandom_range(int'(2 * step))
                            : v + $urandom_range(int'(2 * step));
            endcase
            send_beat(pptw_pkg::CMD_SAMPLE, SLOT_W'($urandom_range(15)), clamp_pressure(v),
                      1'($urandom_range(1)), PCOUNT_W'($urandom_range(31)));
        end
    endtask

    initial
    begin : stimulus
        int target;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_scales(256, 512);

        send_beat(pptw_pkg::CMD_LOAD, 4'd0, 24'sh800000, 1'b0, 5'd0);
        send_beat(pptw_pkg::CMD_LOAD, 4'd1, 24'sh800000, 1'b1, 5'd31);
        for (int i = 2; i < 15; i++)
            send_beat(pptw_pkg::CMD_LOAD, SLOT_W'(i), VALUE_W'((i - 8) * 1000), 1'b0, 5'd0);
        send_beat(pptw_pkg::CMD_LOAD, 4'd15, 24'sh7FFFFF, 1'b0, 5'd0);
        // begin with too few points, then with no nonzero gap
        send_beat(pptw_pkg::CMD_BEGIN, 4'd0, 24'sd0, 1'b0, 5'd0);
        send_beat(pptw_pkg::CMD_BEGIN, 4'd0, 24'sd0, 1'b0, 5'd1);
        send_beat(pptw_pkg::CMD_BEGIN, 4'd0, 24'sd0, 1'b0, 5'd2);
        send_beat(pptw_pkg::CMD_SAMPLE, 4'd0, 24'sd0, 1'b0, 5'd0);
        // oversized count saturates, reverse walk through many points at once
        send_beat(pptw_pkg::CMD_BEGIN, 4'd15, 24'sh7FFFFF, 1'b1, 5'd31);
        send_beat(pptw_pkg::CMD_SAMPLE, 4'd0, 24'sh7FFFFF, 1'b0, 5'd0);
        send_beat(pptw_pkg::CMD_SAMPLE, 4'd0, 24'sh800000, 1'b0, 5'd0);
        send_beat(pptw_pkg::CMD_END, 4'd0, 24'sd0, 1'b0, 5'd0);
        send_beat(pptw_pkg::CMD_SAMPLE, 4'd0, 24'sh800000, 1'b0, 5'd0);
        // forward run to the final point, tracking drops
        send_beat(pptw_pkg::CMD_BEGIN, 4'd0, 24'sd0, 1'b0, 5'd15);
        send_beat(pptw_pkg::CMD_SAMPLE, 4'd0, 24'sh800000, 1'b0, 5'd0);
        send_beat(pptw_pkg::CMD_SAMPLE, 4'd0, 24'sh7FFFFF, 1'b0, 5'd0);
        send_beat(pptw_pkg::CMD_SAMPLE, 4'd0, 24'sh7FFFFF, 1'b0, 5'd0);

        for (int phase = 0; phase < 6; phase++)
        begin
            drain_events();
            case (phase)
                0: write_scales(0, 0);
                1: write_scales(4095, 4095);
                2: write_scales(0, 4095);
                3: write_scales(4095, 0);
                default: write_scales($urandom_range(4095), $urandom_range(4095));
            endcase
            send_idle_pct = (phase < 2) ? 22 : (phase < 4) ? 81 : 0;
            recv_idle_pct = (phase < 2) ? 81 : (phase < 4) ? 22 : 0;
            target = beats_sent + 60;
            while (beats_sent < target)
            begin
                if ($urandom_range(6) == 0)
                    send_noise();
                else
                    run_sweep();
            end
        end
        drain_events();

        if (board.mismatches == 0 && board.expected_events.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
